FILE: rtl/ims_pkg.sv
package ims_pkg;

   localparam int IDX_W             = 12;
   localparam int KIND_W            = 2;
   localparam int COORD_W           = 16;
   localparam int HELD_W            = 13;
   localparam int STAT_W            = 2;
   localparam int KEY_W             = 2 * IDX_W;
   localparam int VERT_W            = 3 * COORD_W;
   localparam int FRAC_BITS         = 14;
   localparam int BASE_COUNT        = 12;
   localparam int DEF_MAX_VERTICES  = 4096;
   localparam int DEF_CACHE_ENTRIES = 4096;

   localparam logic [KIND_W-1:0] KIND_SUBDIV  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESTORE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SPARE   = 2'd3;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

   // Short and long coordinates of the normalized (1, phi, 0) in Q1.14.
   localparam logic [COORD_W-1:0] BASE_A     = 16'd8614;
   localparam logic [COORD_W-1:0] BASE_C     = 16'd13937;
   localparam logic [COORD_W-1:0] BASE_NEG_A = ~BASE_A + 16'd1;
   localparam logic [COORD_W-1:0] BASE_NEG_C = ~BASE_C + 16'd1;
   localparam logic [COORD_W-1:0] BASE_ZERO  = 16'd0;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_VREAD, S_VWAIT, S_SCAN_RD, S_SCAN_CMP, S_CHECK,
      S_EDGE, S_RD_A, S_RD_B, S_NORM_GO, S_NORM_WAIT, S_EMIT
   } top_state_type;

   typedef enum logic [2:0] {
      N_IDLE, N_SQ, N_SUM, N_ROOT, N_LOAD, N_DIV, N_DONE
   } norm_state_type;

   typedef struct packed {
      logic                      done;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } norm_res_type;

   function automatic logic [VERT_W-1:0] base_vertex(input logic [3:0] idx);
      logic [VERT_W-1:0] v;
      case (idx)
         4'd0:    v = {BASE_NEG_A, BASE_C, BASE_ZERO};
         4'd1:    v = {BASE_A, BASE_C, BASE_ZERO};
         4'd2:    v = {BASE_NEG_A, BASE_NEG_C, BASE_ZERO};
         4'd3:    v = {BASE_A, BASE_NEG_C, BASE_ZERO};
         4'd4:    v = {BASE_ZERO, BASE_NEG_A, BASE_C};
         4'd5:    v = {BASE_ZERO, BASE_A, BASE_C};
         4'd6:    v = {BASE_ZERO, BASE_NEG_A, BASE_NEG_C};
         4'd7:    v = {BASE_ZERO, BASE_A, BASE_NEG_C};
         4'd8:    v = {BASE_C, BASE_ZERO, BASE_NEG_A};
         4'd9:    v = {BASE_C, BASE_ZERO, BASE_A};
         4'd10:   v = {BASE_NEG_C, BASE_ZERO, BASE_NEG_A};
         4'd11:   v = {BASE_NEG_C, BASE_ZERO, BASE_A};
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [KEY_W-1:0] edge_key(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      return (a < b) ? {a, b} : {b, a};
   endfunction

endpackage

FILE: rtl/ims_norm.sv
module ims_norm (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [ims_pkg::COORD_W:0]   sum_x,
   input  logic signed [ims_pkg::COORD_W:0]   sum_y,
   input  logic signed [ims_pkg::COORD_W:0]   sum_z,
   output ims_pkg::norm_res_type              result
);
   import ims_pkg::*;

   localparam int MAG_W   = COORD_W;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int NUM_W   = MAG_W + FRAC_BITS + 1;
   localparam int STEPS_W = $clog2(NUM_W);
   localparam int ROOT_STEPS = SQ_W / 2;

   norm_state_type state_ff, state_in;
   logic [MAG_W-1:0]   mag_ff [3];
   logic [MAG_W-1:0]   mag_in [3];
   logic               neg_ff [3];
   logic               neg_in [3];
   logic [SQ_W-1:0]    sq_ff [3];
   logic [SQ_W-1:0]    sq_in [3];
   logic [COORD_W-1:0] res_ff [3];
   logic [COORD_W-1:0] res_in [3];
   logic [SQ_W-1:0]    rad_ff, rad_in;
   logic [SQ_W-1:0]    root_ff, root_in;
   logic [SQ_W-1:0]    sqbit_ff, sqbit_in;
   logic [STEPS_W-1:0] cnt_ff, cnt_in;
   logic [1:0]         axis_ff, axis_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [MAG_W-1:0]   rem_ff, rem_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;

   logic signed [COORD_W:0] sums [3];
   logic [SQ_W-1:0]    trial;
   logic [MAG_W:0]     rem_shift;
   logic               qbit;
   logic [NUM_W-1:0]   qfin;
   logic [NUM_W-1:0]   qclamp;
   logic [COORD_W-1:0] qout;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      sq_ff    <= sq_in;
      res_ff   <= res_in;
      rad_ff   <= rad_in;
      root_ff  <= root_in;
      sqbit_ff <= sqbit_in;
      cnt_ff   <= cnt_in;
      axis_ff  <= axis_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
   end

   always_comb begin
      sums[0] = sum_x;
      sums[1] = sum_y;
      sums[2] = sum_z;
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      sq_in    = sq_ff;
      res_in   = res_ff;
      rad_in   = rad_ff;
      root_in  = root_ff;
      sqbit_in = sqbit_ff;
      cnt_in   = cnt_ff;
      axis_in  = axis_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      trial     = root_ff + sqbit_ff;
      rem_shift = {rem_ff, num_ff[NUM_W-1]};
      qbit      = rem_shift >= {1'b0, root_ff[MAG_W-1:0]};
      qfin      = {quo_ff[NUM_W-2:0], qbit};
      qclamp    = (qfin > (NUM_W'(1) << FRAC_BITS)) ? (NUM_W'(1) << FRAC_BITS) : qfin;
      qout      = neg_ff[0] ? (~qclamp[COORD_W-1:0] + 1'b1) : qclamp[COORD_W-1:0];
      case (state_ff)
         N_IDLE: begin
            if (start) begin
               for (int j = 0; j < 3; j++) begin
                  neg_in[j] = sums[j][COORD_W];
                  mag_in[j] = sums[j][COORD_W] ? MAG_W'(-sums[j]) : MAG_W'(sums[j]);
               end
               state_in = N_SQ;
            end
         end
         N_SQ: begin
            for (int j = 0; j < 3; j++) begin
               sq_in[j] = mag_ff[j] * mag_ff[j];
            end
            state_in = N_SUM;
         end
         N_SUM: begin
            rad_in   = sq_ff[0] + sq_ff[1] + sq_ff[2];
            root_in  = '0;
            sqbit_in = SQ_W'(1) << (SQ_W - 2);
            cnt_in   = '0;
            state_in = N_ROOT;
         end
         N_ROOT: begin
            if (rad_ff >= trial) begin
               rad_in  = rad_ff - trial;
               root_in = (root_ff >> 1) + sqbit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            sqbit_in = sqbit_ff >> 2;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == STEPS_W'(ROOT_STEPS - 1)) begin
               axis_in  = '0;
               state_in = N_LOAD;
            end
         end
         N_LOAD: begin
            if (root_ff == '0) begin
               for (int j = 0; j < 3; j++) begin
                  res_in[j] = '0;
               end
               state_in = N_DONE;
            end else begin
               num_in   = (NUM_W'(mag_ff[0]) << FRAC_BITS) + NUM_W'(root_ff[MAG_W-1:1]);
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = '0;
               state_in = N_DIV;
            end
         end
         N_DIV: begin
            if (qbit) begin
               rem_in = MAG_W'(rem_shift - {1'b0, root_ff[MAG_W-1:0]});
            end else begin
               rem_in = rem_shift[MAG_W-1:0];
            end
            quo_in = qfin;
            num_in = num_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEPS_W'(NUM_W - 1)) begin
               res_in[0] = res_ff[1];
               res_in[1] = res_ff[2];
               res_in[2] = qout;
               mag_in[0] = mag_ff[1];
               mag_in[1] = mag_ff[2];
               neg_in[0] = neg_ff[1];
               neg_in[1] = neg_ff[2];
               axis_in   = axis_ff + 1'b1;
               state_in  = (axis_ff == 2'd2) ? N_DONE : N_LOAD;
            end
         end
         N_DONE: begin
            state_in = N_IDLE;
         end
         default: begin
            state_in = N_IDLE;
         end
      endcase
   end

   assign result.done = (state_ff == N_DONE);
   assign result.x    = res_ff[0];
   assign result.y    = res_ff[1];
   assign result.z    = res_ff[2];

endmodule

FILE: rtl/icosphere_midpoint_subdivider_core.sv
// Channel  Direction  Ports                                        Items
// req      in         req_valid/req_ready, kind and three indices  one per command
// rsp      out        rsp_valid/rsp_ready, corners, coords, status one to four
// A read passes decode, the vertex read and its wait before showing its result; restore,
// the spare kind and errors found at decode show theirs straight after decode.
// A subdivide runs decode, a read and a compare per cache entry and a fill check, then
// settles a reused edge directly and a new midpoint in the shared root and divide unit.
// Reset returns the vertex count to 12 and empties the cache at once.
// No new item is taken until the last result is taken and the core is back in idle.
module icosphere_midpoint_subdivider_core #(
   parameter int MAX_VERTICES  = ims_pkg::DEF_MAX_VERTICES,
   parameter int CACHE_ENTRIES = ims_pkg::DEF_CACHE_ENTRIES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ims_pkg::KIND_W-1:0]         req_kind,
   input  logic [ims_pkg::IDX_W-1:0]          req_first_index,
   input  logic [ims_pkg::IDX_W-1:0]          req_second_index,
   input  logic [ims_pkg::IDX_W-1:0]          req_third_index,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ims_pkg::IDX_W-1:0]          rsp_corner_one,
   output logic [ims_pkg::IDX_W-1:0]          rsp_corner_two,
   output logic [ims_pkg::IDX_W-1:0]          rsp_corner_three,
   output logic signed [ims_pkg::COORD_W-1:0] rsp_coord_x,
   output logic signed [ims_pkg::COORD_W-1:0] rsp_coord_y,
   output logic signed [ims_pkg::COORD_W-1:0] rsp_coord_z,
   output logic [ims_pkg::HELD_W-1:0]         rsp_vertices_held,
   output logic [ims_pkg::STAT_W-1:0]         rsp_status,
   output logic                               rsp_last
);
   import ims_pkg::*;

   localparam int VIDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int CE_W   = $clog2(CACHE_ENTRIES);
   localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int LIM    = (MAX_VERTICES > CACHE_ENTRIES) ? MAX_VERTICES : CACHE_ENTRIES;
   localparam int SUM_W  = $clog2(LIM + 4) + 1;

   top_state_type state_ff, state_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [IDX_W-1:0]  v0_ff, v0_in, v1_ff, v1_in, v2_ff, v2_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [2:0]        hit_ff, hit_in;
   logic [VIDX_W-1:0] hitval_ff [3];
   logic [VIDX_W-1:0] hitval_in [3];
   logic [VIDX_W-1:0] mid_ff [3];
   logic [VIDX_W-1:0] mid_in [3];
   logic [1:0]        edge_sel_ff, edge_sel_in;
   logic [VERT_W-1:0] va_ff, va_in;
   logic [VERT_W-1:0] coord_ff, coord_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              tri_ff, tri_in;
   logic [1:0]        emit_ff, emit_in;

   logic [VERT_W-1:0] vstore_mem [MAX_VERTICES];
   logic [KEY_W-1:0]  key_mem [CACHE_ENTRIES];
   logic [VERT_W-1:0] vrd_ff;
   logic              vbase_ff;
   logic [3:0]        vidx_ff;
   logic [KEY_W-1:0]  key_rd_ff;

   logic [VIDX_W-1:0] v_raddr, v_waddr;
   logic              v_we, k_we;
   logic [VERT_W-1:0] v_wdata, vdata;
   logic [CE_W-1:0]   k_raddr, k_waddr;
   logic [KEY_W-1:0]  k_wdata;

   logic [KEY_W-1:0]  key_arr [3];
   logic [KEY_W-1:0]  cur_key;
   logic [IDX_W-1:0]  cur_a, cur_b;
   logic              cur_hit;
   logic [VIDX_W-1:0] cur_hitval;
   logic [CNT_W-1:0]  used;
   logic [1:0]        need;
   logic              full;
   logic              fin;
   logic [VIDX_W-1:0] fin_val;
   logic              in0, in1, in2;
   logic              norm_start;
   logic signed [COORD_W:0] sum_x, sum_y, sum_z;
   norm_res_type      norm_res;

   ims_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .sum_x  (sum_x),
      .sum_y  (sum_y),
      .sum_z  (sum_z),
      .result (norm_res)
   );

   always_ff @(posedge clock) begin
      vrd_ff    <= vstore_mem[v_raddr];
      vbase_ff  <= (v_raddr < VIDX_W'(BASE_COUNT));
      vidx_ff   <= v_raddr[3:0];
      key_rd_ff <= key_mem[k_raddr];
      if (v_we) begin
         vstore_mem[v_waddr] <= v_wdata;
      end
      if (k_we) begin
         key_mem[k_waddr] <= k_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= CNT_W'(BASE_COUNT);
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
      end
      kind_ff     <= kind_in;
      v0_ff       <= v0_in;
      v1_ff       <= v1_in;
      v2_ff       <= v2_in;
      scan_ff     <= scan_in;
      hit_ff      <= hit_in;
      hitval_ff   <= hitval_in;
      mid_ff      <= mid_in;
      edge_sel_ff <= edge_sel_in;
      va_ff       <= va_in;
      coord_ff    <= coord_in;
      status_ff   <= status_in;
      tri_ff      <= tri_in;
      emit_ff     <= emit_in;
   end

   assign vdata = vbase_ff ? base_vertex(vidx_ff) : vrd_ff;

   always_comb begin
      key_arr[0] = edge_key(v0_ff, v1_ff);
      key_arr[1] = edge_key(v1_ff, v2_ff);
      key_arr[2] = edge_key(v0_ff, v2_ff);
      case (edge_sel_ff)
         2'd0: begin
            cur_a = v0_ff; cur_b = v1_ff; cur_key = key_arr[0];
            cur_hit = hit_ff[0]; cur_hitval = hitval_ff[0];
         end
         2'd1: begin
            cur_a = v1_ff; cur_b = v2_ff; cur_key = key_arr[1];
            cur_hit = hit_ff[1]; cur_hitval = hitval_ff[1];
         end
         default: begin
            cur_a = v0_ff; cur_b = v2_ff; cur_key = key_arr[2];
            cur_hit = hit_ff[2]; cur_hitval = hitval_ff[2];
         end
      endcase
      in0  = CMP_W'(v0_ff) < CMP_W'(total_ff);
      in1  = CMP_W'(v1_ff) < CMP_W'(total_ff);
      in2  = CMP_W'(v2_ff) < CMP_W'(total_ff);
      used = total_ff - CNT_W'(BASE_COUNT);
      need = {1'b0, ~hit_ff[0]}
           + {1'b0, (key_arr[1] != key_arr[0]) && !hit_ff[1]}
           + {1'b0, (key_arr[2] != key_arr[0]) && (key_arr[2] != key_arr[1])
                    && !hit_ff[2]};
      full = (SUM_W'(total_ff) + SUM_W'(need) > SUM_W'(MAX_VERTICES))
          || (SUM_W'(used) + SUM_W'(need) > SUM_W'(CACHE_ENTRIES));
      sum_x = {va_ff[3*COORD_W-1], va_ff[3*COORD_W-1:2*COORD_W]}
            + {vdata[3*COORD_W-1], vdata[3*COORD_W-1:2*COORD_W]};
      sum_y = {va_ff[2*COORD_W-1], va_ff[2*COORD_W-1:COORD_W]}
            + {vdata[2*COORD_W-1], vdata[2*COORD_W-1:COORD_W]};
      sum_z = {va_ff[COORD_W-1], va_ff[COORD_W-1:0]}
            + {vdata[COORD_W-1], vdata[COORD_W-1:0]};
   end

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      v0_in       = v0_ff;
      v1_in       = v1_ff;
      v2_in       = v2_ff;
      total_in    = total_ff;
      scan_in     = scan_ff;
      hit_in      = hit_ff;
      hitval_in   = hitval_ff;
      mid_in      = mid_ff;
      edge_sel_in = edge_sel_ff;
      va_in       = va_ff;
      coord_in    = coord_ff;
      status_in   = status_ff;
      tri_in      = tri_ff;
      emit_in     = emit_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      v_raddr     = '0;
      v_we        = 1'b0;
      v_waddr     = VIDX_W'(total_ff);
      v_wdata     = {norm_res.x, norm_res.y, norm_res.z};
      k_raddr     = CE_W'(scan_ff);
      k_we        = 1'b0;
      k_waddr     = CE_W'(used);
      k_wdata     = cur_key;
      norm_start  = 1'b0;
      fin         = 1'b0;
      fin_val     = cur_hitval;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in  = req_kind;
               v0_in    = req_first_index;
               v1_in    = req_second_index;
               v2_in    = req_third_index;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            coord_in  = '0;
            tri_in    = 1'b0;
            emit_in   = '0;
            status_in = STATUS_OK;
            state_in  = S_EMIT;
            case (kind_ff)
               KIND_READ: begin
                  if (in0) begin
                     state_in = S_VREAD;
                  end else begin
                     status_in = STATUS_RANGE;
                  end
               end
               KIND_RESTORE: begin
                  total_in = CNT_W'(BASE_COUNT);
               end
               KIND_SUBDIV: begin
                  if (in0 && in1 && in2) begin
                     hit_in   = '0;
                     scan_in  = '0;
                     state_in = (used == '0) ? S_CHECK : S_SCAN_RD;
                  end else begin
                     status_in = STATUS_RANGE;
                  end
               end
               default: begin
                  status_in = STATUS_OK;
               end
            endcase
         end
         S_VREAD: begin
            v_raddr  = VIDX_W'(v0_ff);
            state_in = S_VWAIT;
         end
         S_VWAIT: begin
            coord_in = vdata;
            state_in = S_EMIT;
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            for (int j = 0; j < 3; j++) begin
               if (!hit_ff[j] && (key_rd_ff == key_arr[j])) begin
                  hit_in[j]    = 1'b1;
                  hitval_in[j] = VIDX_W'(scan_ff + CNT_W'(BASE_COUNT));
               end
            end
            scan_in  = scan_ff + 1'b1;
            state_in = (scan_ff + 1'b1 == used) ? S_CHECK : S_SCAN_RD;
         end
         S_CHECK: begin
            if (full) begin
               status_in = STATUS_FULL;
               state_in  = S_EMIT;
            end else begin
               edge_sel_in = '0;
               state_in    = S_EDGE;
            end
         end
         S_EDGE: begin
            if ((edge_sel_ff == 2'd1) && (key_arr[1] == key_arr[0])) begin
               fin = 1'b1; fin_val = mid_ff[0];
            end else if ((edge_sel_ff == 2'd2) && (key_arr[2] == key_arr[0])) begin
               fin = 1'b1; fin_val = mid_ff[0];
            end else if ((edge_sel_ff == 2'd2) && (key_arr[2] == key_arr[1])) begin
               fin = 1'b1; fin_val = mid_ff[1];
            end else if (cur_hit) begin
               fin = 1'b1; fin_val = cur_hitval;
            end else begin
               state_in = S_RD_A;
            end
         end
         S_RD_A: begin
            v_raddr  = VIDX_W'(cur_a);
            state_in = S_RD_B;
         end
         S_RD_B: begin
            v_raddr  = VIDX_W'(cur_b);
            va_in    = vdata;
            state_in = S_NORM_GO;
         end
         S_NORM_GO: begin
            norm_start = 1'b1;
            state_in   = S_NORM_WAIT;
         end
         S_NORM_WAIT: begin
            if (norm_res.done) begin
               v_we     = 1'b1;
               k_we     = 1'b1;
               total_in = total_ff + 1'b1;
               fin      = 1'b1;
               fin_val  = VIDX_W'(total_ff);
            end
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (rsp_last) begin
                  state_in = S_IDLE;
               end else begin
                  emit_in = emit_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (fin) begin
         case (edge_sel_ff)
            2'd0:    mid_in[0] = fin_val;
            2'd1:    mid_in[1] = fin_val;
            default: mid_in[2] = fin_val;
         endcase
         if (edge_sel_ff == 2'd2) begin
            status_in = STATUS_OK;
            coord_in  = '0;
            tri_in    = 1'b1;
            emit_in   = '0;
            state_in  = S_EMIT;
         end else begin
            edge_sel_in = edge_sel_ff + 1'b1;
            state_in    = S_EDGE;
         end
      end
   end

   always_comb begin
      rsp_corner_one   = '0;
      rsp_corner_two   = '0;
      rsp_corner_three = '0;
      if (tri_ff) begin
         case (emit_ff)
            2'd0: begin
               rsp_corner_one   = v0_ff;
               rsp_corner_two   = IDX_W'(mid_ff[0]);
               rsp_corner_three = IDX_W'(mid_ff[2]);
            end
            2'd1: begin
               rsp_corner_one   = v1_ff;
               rsp_corner_two   = IDX_W'(mid_ff[1]);
               rsp_corner_three = IDX_W'(mid_ff[0]);
            end
            2'd2: begin
               rsp_corner_one   = v2_ff;
               rsp_corner_two   = IDX_W'(mid_ff[2]);
               rsp_corner_three = IDX_W'(mid_ff[1]);
            end
            default: begin
               rsp_corner_one   = IDX_W'(mid_ff[0]);
               rsp_corner_two   = IDX_W'(mid_ff[1]);
               rsp_corner_three = IDX_W'(mid_ff[2]);
            end
         endcase
      end
   end

   assign rsp_coord_x       = coord_ff[3*COORD_W-1:2*COORD_W];
   assign rsp_coord_y       = coord_ff[2*COORD_W-1:COORD_W];
   assign rsp_coord_z       = coord_ff[COORD_W-1:0];
   assign rsp_vertices_held = HELD_W'(total_ff);
   assign rsp_status        = status_ff;
   assign rsp_last          = !tri_ff || (emit_ff == 2'd3);

endmodule
